// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared definitions for the eased scroll camera
// Transaction kind codes, register indexes, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   // Input transaction kinds
   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_RETARGET = 2'd1;
   localparam logic [1:0] KIND_VTARGET  = 2'd2;
   localparam logic [1:0] KIND_INIT     = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOKAHEAD_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_X          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_Y          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_OFFSET_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_OFFSET_Y = 3'd5;
   localparam int unsigned CSR_DATA_W = 8;

   // Ease progress runs 0..EASE_FULL; EASE_FULL means no move active
   localparam logic [8:0] EASE_FULL = 9'd256;

   // Fixed vertical base offset of the camera relative to the player
   localparam logic [15:0] BASE_Y = 16'hFFE8;  // -24

   // Shared multiplier widths
   localparam int unsigned MUL_A_W = 17;
   localparam int unsigned MUL_B_W = 10;
   localparam int unsigned MUL_P_W = 25;

   // Tick sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCALE,
      ST_APPLY,
      ST_SUM
   } esc_state_type;

endpackage

`default_nettype wire

// ===== src/eased_scroll_camera.sv =====
// ----------------------------------------------------------------------------
// eased_scroll_camera: side-scrolling camera with eased horizontal lookahead
// Keeps horizontal and vertical camera offsets and emits a scroll position on
// every frame tick.
// ----------------------------------------------------------------------------
// Init, horizontal retarget and vertical target transactions produce no
// result. A tick during a move passes from acceptance to the output
// register through the steps acceptance, square, scale, apply and sum. A
// tick with no move active, or one that ends the move, passes through
// acceptance and sum only. Either waits in the sum step while the output
// register is still held by a stalled result; the block takes no new
// transaction until the tick is finished. The one shared 17x10 multiplier
// is used first for the easing square and then for scaling the move span.
`default_nettype none

module eased_scroll_camera (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_write,
   input  wire logic [esc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [esc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_kind,
   input  wire logic signed [7:0]                   req_lookahead,
   input  wire logic signed [15:0]                  req_player_x,
   input  wire logic signed [15:0]                  req_player_y,
   input  wire logic                                req_heading_left,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [15:0]                       rsp_scroll_x,
   output logic signed [15:0]                       rsp_scroll_y
);

   import esc_pkg::*;

   // Configuration registers
   logic [6:0] lookahead_x_ff, lookahead_x_in;
   logic [7:0] step_x_ff, step_x_in;
   logic [6:0] step_y_ff, step_y_in;
   logic [7:0] half_width_ff, half_width_in;
   logic [7:0] screen_offset_x_ff, screen_offset_x_in;
   logic [7:0] screen_offset_y_ff, screen_offset_y_in;

   // Camera state
   logic [15:0] offset_x_ff, offset_x_in;
   logic [15:0] move_start_x_ff, move_start_x_in;
   logic [15:0] move_span_x_ff, move_span_x_in;
   logic [8:0]  ease_progress_ff, ease_progress_in;
   logic [15:0] pan_y_ff, pan_y_in;
   logic [7:0]  pan_target_y_ff, pan_target_y_in;

   // Sequencer and working registers
   esc_state_type state_ff, state_in;
   logic [MUL_P_W-1:0] mul_ff, mul_in;
   logic [15:0] px_ff, px_in;
   logic [15:0] py_ff, py_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] scroll_x_ff, scroll_x_in;
   logic [15:0] scroll_y_ff, scroll_y_in;

   // Combinational helpers
   logic                      accept;
   logic                      out_free;
   logic [15:0]               follow_x;
   logic [9:0]                progress_sum;
   logic [7:0]                t_lo;
   logic [7:0]                sq_op;
   logic [8:0]                sq_val;
   logic [9:0]                curve_val;
   logic [8:0]                eased;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
   logic signed [16:0]        pan_cur;
   logic signed [16:0]        pan_tgt;
   logic signed [16:0]        pan_up;
   logic signed [16:0]        pan_dn;
   logic signed [16:0]        pan_next;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scroll_x = scroll_x_ff;
   assign rsp_scroll_y = scroll_y_ff;

   // Follow offset from player facing
   assign follow_x = req_heading_left ? (16'd0 - {9'd0, lookahead_x_ff})
                                      : {9'd0, lookahead_x_ff};

   // Progress after one tick
   assign progress_sum = {1'b0, ease_progress_ff} + {2'b00, step_x_ff};

   // Easing square operand: t in the first half, 256 - t in the second
   assign t_lo  = ease_progress_ff[7:0];
   assign sq_op = t_lo[7] ? 8'(9'd256 - {1'b0, t_lo}) : t_lo;

   // Easing curve from the registered square, then halved; the top of the
   // curve halves to 256 and needs the ninth bit
   assign sq_val    = mul_ff[14:6];
   assign curve_val = t_lo[7] ? (10'd512 - {1'b0, sq_val}) : {1'b0, sq_val};
   assign eased     = curve_val[9:1];

   // Shared multiplier operand select
   always_comb begin
      if (state_ff == ST_SQUARE) begin
         mul_a = $signed({9'd0, sq_op});
         mul_b = $signed({2'b00, sq_op});
      end else begin
         mul_a = $signed({move_span_x_ff[15], move_span_x_ff});
         mul_b = $signed({1'b0, eased});
      end
   end
   assign mul_p = mul_a * mul_b;

   // Vertical slew toward target with clamp
   assign pan_cur = $signed({pan_y_ff[15], pan_y_ff});
   assign pan_tgt = $signed({{9{pan_target_y_ff[7]}}, pan_target_y_ff});
   assign pan_up  = pan_cur + $signed({10'd0, step_y_ff});
   assign pan_dn  = pan_cur - $signed({10'd0, step_y_ff});
   always_comb begin
      if (pan_cur < pan_tgt) begin
         pan_next = (pan_up > pan_tgt) ? pan_tgt : pan_up;
      end else if (pan_cur > pan_tgt) begin
         pan_next = (pan_dn < pan_tgt) ? pan_tgt : pan_dn;
      end else begin
         pan_next = pan_cur;
      end
   end

   // Next state and register updates
   always_comb begin
      lookahead_x_in     = lookahead_x_ff;
      step_x_in          = step_x_ff;
      step_y_in          = step_y_ff;
      half_width_in      = half_width_ff;
      screen_offset_x_in = screen_offset_x_ff;
      screen_offset_y_in = screen_offset_y_ff;
      offset_x_in        = offset_x_ff;
      move_start_x_in    = move_start_x_ff;
      move_span_x_in     = move_span_x_ff;
      ease_progress_in   = ease_progress_ff;
      pan_y_in           = pan_y_ff;
      pan_target_y_in    = pan_target_y_ff;
      state_in           = state_ff;
      mul_in             = mul_ff;
      px_in              = px_ff;
      py_in              = py_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      scroll_x_in        = scroll_x_ff;
      scroll_y_in        = scroll_y_ff;

      // Configuration writes
      if (csr_write) begin
         case (csr_index)
            CSR_LOOKAHEAD_X:     lookahead_x_in     = csr_wdata[6:0];
            CSR_STEP_X:          step_x_in          = csr_wdata;
            CSR_STEP_Y:          step_y_in          = csr_wdata[6:0];
            CSR_HALF_WIDTH:      half_width_in      = csr_wdata;
            CSR_SCREEN_OFFSET_X: screen_offset_x_in = csr_wdata;
            CSR_SCREEN_OFFSET_Y: screen_offset_y_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_INIT: begin
                     offset_x_in      = follow_x;
                     move_span_x_in   = 16'd0;
                     ease_progress_in = EASE_FULL;
                     pan_y_in         = 16'd0;
                     pan_target_y_in  = 8'd0;
                  end
                  KIND_RETARGET: begin
                     move_start_x_in  = offset_x_ff;
                     move_span_x_in   = {{8{req_lookahead[7]}}, req_lookahead} - offset_x_ff;
                     ease_progress_in = EASE_FULL - ease_progress_ff;
                  end
                  KIND_VTARGET: begin
                     pan_target_y_in = req_lookahead;
                  end
                  KIND_TICK: begin
                     px_in    = req_player_x;
                     py_in    = req_player_y;
                     pan_y_in = pan_next[15:0];
                     if (ease_progress_ff == EASE_FULL) begin
                        offset_x_in = follow_x;
                        state_in    = ST_SUM;
                     end else if (progress_sum >= {1'b0, EASE_FULL}) begin
                        ease_progress_in = EASE_FULL;
                        offset_x_in      = move_start_x_ff + move_span_x_ff;
                        state_in         = ST_SUM;
                     end else begin
                        ease_progress_in = progress_sum[8:0];
                        state_in         = ST_SQUARE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Square the progress term
         ST_SQUARE: begin
            mul_in   = mul_p[MUL_P_W-1:0];
            state_in = ST_SCALE;
         end
         // Scale the span by the eased fraction
         ST_SCALE: begin
            mul_in   = mul_p[MUL_P_W-1:0];
            state_in = ST_APPLY;
         end
         // Add the floored delta to the move start
         ST_APPLY: begin
            offset_x_in = move_start_x_ff + mul_ff[23:8];
            state_in    = ST_SUM;
         end
         // Form the scroll position once the output register is free
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               scroll_x_in  = px_ff + {8'd0, half_width_ff} + offset_x_ff
                              - {8'd0, screen_offset_x_ff};
               scroll_y_in  = py_ff + BASE_Y + pan_y_ff - {8'd0, screen_offset_y_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration, camera state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         lookahead_x_ff     <= 7'd32;
         step_x_ff          <= 8'd8;
         step_y_ff          <= 7'd1;
         half_width_ff      <= 8'd8;
         screen_offset_x_ff <= 8'd80;
         screen_offset_y_ff <= 8'd72;
         offset_x_ff        <= 16'd32;
         move_start_x_ff    <= 16'd0;
         move_span_x_ff     <= 16'd0;
         ease_progress_ff   <= EASE_FULL;
         pan_y_ff           <= 16'd0;
         pan_target_y_ff    <= 8'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         lookahead_x_ff     <= lookahead_x_in;
         step_x_ff          <= step_x_in;
         step_y_ff          <= step_y_in;
         half_width_ff      <= half_width_in;
         screen_offset_x_ff <= screen_offset_x_in;
         screen_offset_y_ff <= screen_offset_y_in;
         offset_x_ff        <= offset_x_in;
         move_start_x_ff    <= move_start_x_in;
         move_span_x_ff     <= move_span_x_in;
         ease_progress_ff   <= ease_progress_in;
         pan_y_ff           <= pan_y_in;
         pan_target_y_ff    <= pan_target_y_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      mul_ff      <= mul_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      scroll_x_ff <= scroll_x_in;
      scroll_y_ff <= scroll_y_in;
   end

   // A result only appears after the sum step
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SUM))
      else $error("result loaded outside the sum step");

   // Progress never passes the full mark
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      ease_progress_ff <= EASE_FULL)
      else $error("ease progress out of range");

   // The multiplier path is only taken for a move still in progress
   a_square_moving: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> (ease_progress_ff < EASE_FULL))
      else $error("square step entered with no active move");

   // A tick that enters the multiplier path reaches the sum step after the scale and apply steps
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> ##3 (state_ff == ST_SUM))
      else $error("tick sequence broken");

endmodule

`default_nettype wire
